[hw/rtl/svr_pkg.sv]
`default_nettype none

package svr_pkg;

    // build-time defaults
    localparam int ID_BYTES_DEF = 32;

    // configuration port
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_WORD0      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_WORD1      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_WORD2      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_WORD3      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUIRE_UNSPENT = 3'd4;
    localparam int ID_WORD_BYTES = 8;

    // record layout
    localparam int CNT_W = 6;
    localparam logic [CNT_W-1:0] POS_VERSION_LO = 6'd4;
    localparam logic [CNT_W-1:0] POS_VERSION_HI = 6'd5;
    localparam logic [CNT_W-1:0] POS_STATE      = 6'd6;
    localparam logic [CNT_W-1:0] POS_RESERVED   = 6'd7;
    localparam logic [CNT_W-1:0] POS_ID_FIRST   = 6'd8;
    localparam logic [CNT_W-1:0] POS_CRC_FIRST  = 6'd40;
    localparam logic [CNT_W-1:0] POS_LAST       = 6'd43;
    localparam logic [CNT_W-1:0] COUNT_MAX      = 6'd63;
    localparam int ID_FIRST_POS = 8;

    localparam logic [31:0] REC_MAGIC = 32'h4E55564C;
    localparam logic [7:0]  REC_VERSION_LO = 8'h01;
    localparam logic [7:0]  REC_VERSION_HI = 8'h00;
    localparam logic [7:0]  REC_RESERVED   = 8'h00;
    localparam logic [7:0]  ST_UNSPENT     = 8'h01;
    localparam logic [7:0]  ST_SPENT       = 8'h02;

    // reflected crc-32
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

    typedef enum logic [3:0] {
        ERR_OK       = 4'd0,
        ERR_LENGTH   = 4'd1,
        ERR_MAGIC    = 4'd2,
        ERR_VERSION  = 4'd3,
        ERR_RESERVED = 4'd4,
        ERR_STATE    = 4'd5,
        ERR_ID       = 4'd6,
        ERR_CRC      = 4'd7,
        ERR_SPENT    = 4'd8
    } t_err;

    typedef struct packed {
        logic       ok;
        t_err       code;
        logic [7:0] state;
    } t_verdict;

    // magic byte at offset sel, little-endian
    function automatic logic [7:0] magic_byte(input logic [1:0] sel);
        return REC_MAGIC[{sel, 3'b000} +: 8];
    endfunction

    // keep the lowest nonzero error code
    function automatic t_err pick_err(input t_err cur, input t_err code);
        if (code == ERR_OK) begin
            return cur;
        end
        if (cur == ERR_OK || code < cur) begin
            return code;
        end
        return cur;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/svr_stream_if.sv]
`default_nettype none

// record byte channel
interface svr_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;
    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

// verdict channel
interface svr_result_if;
    logic       valid;
    logic       ready;
    logic       record_ok;
    logic [3:0] error_code;
    logic [7:0] record_state;
    modport source (output valid, output record_ok, output error_code,
                    output record_state, input ready);
    modport sink   (input valid, input record_ok, input error_code,
                    input record_state, output ready);
endinterface

`default_nettype wire

[hw/rtl/state_record_validator_top.sv]
`default_nettype none
// a record's last byte is taken into the input register and its verdict into the output register
// throughput: one byte per cycle, sustained across records unless stalled; the byte-wide
//   crc update and field checks between the input and record registers set this
// a verdict held in the output register stalls only a following last byte
// reset: synchronous active-low i_rst_n clears record state, id and mode registers

module state_record_validator_top #(
    parameter int ID_BYTES = svr_pkg::ID_BYTES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    svr_item_if.sink                           i_item,
    svr_result_if.source                       o_result,
    input  wire logic                          i_cfg_we,
    input  wire logic [svr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [svr_pkg::CFG_W-1:0]     i_cfg_data
);

    logic                     r_in_valid;
    logic [7:0]               r_in_byte;
    logic                     r_in_last;
    logic                     r_out_valid;
    svr_pkg::t_verdict        r_out;
    logic [ID_BYTES-1:0][7:0] r_id;
    logic                     r_require_unspent;
    logic                     advance;
    logic                     verdict_valid;
    svr_pkg::t_verdict        verdict;

    // id bytes, one register per compared byte
    for (genvar g = 0; g < ID_BYTES; g++) begin : g_id
        localparam int WORD = g / svr_pkg::ID_WORD_BYTES;
        localparam int HI   = svr_pkg::CFG_W - 1 - 8 * (g % svr_pkg::ID_WORD_BYTES);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_id[g] <= '0;
            end else if (i_cfg_we && i_cfg_idx == svr_pkg::CFG_IDX_W'(WORD)) begin
                r_id[g] <= i_cfg_data[HI -: 8];
            end
        end
    end

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_require_unspent <= 1'b0;
        end else if (i_cfg_we && i_cfg_idx == svr_pkg::CFG_REQUIRE_UNSPENT) begin
            r_require_unspent <= i_cfg_data[0];
        end
    end

    // a last byte waits while the previous verdict is not yet taken
    assign advance      = r_in_valid && !(r_in_last && r_out_valid && !o_result.ready);
    assign i_item.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in_byte <= i_item.data_byte;
            r_in_last <= i_item.is_last;
        end
    end

    svr_record_core #(
        .ID_BYTES (ID_BYTES)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_advance         (advance),
        .i_byte            (r_in_byte),
        .i_last            (r_in_last),
        .i_id              (r_id),
        .i_require_unspent (r_require_unspent),
        .o_verdict_valid   (verdict_valid),
        .o_verdict         (verdict)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (verdict_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (verdict_valid) begin
            r_out <= verdict;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.record_ok    = r_out.ok;
    assign o_result.error_code   = r_out.code;
    assign o_result.record_state = r_out.state;

endmodule

`default_nettype wire

[hw/rtl/svr_crc_byte.sv]
`default_nettype none

module svr_crc_byte (
    input  wire logic [31:0] i_crc,
    input  wire logic [7:0]  i_byte,
    output logic      [31:0] o_crc
);

    // eight reflected shift steps for one byte
    always_comb begin
        logic [31:0] c;
        c = i_crc ^ {24'b0, i_byte};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ svr_pkg::CRC_POLY) : (c >> 1);
        end
        o_crc = c;
    end

endmodule

`default_nettype wire

[hw/rtl/svr_record_core.sv]
`default_nettype none

module svr_record_core #(
    parameter int ID_BYTES = svr_pkg::ID_BYTES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_advance,
    input  wire logic [7:0]               i_byte,
    input  wire logic                     i_last,
    input  wire logic [ID_BYTES-1:0][7:0] i_id,
    input  wire logic                     i_require_unspent,
    output logic                          o_verdict_valid,
    output svr_pkg::t_verdict             o_verdict
);

    logic [svr_pkg::CNT_W-1:0] r_count, n_count;
    logic [31:0]               r_crc, n_crc;
    logic [31:0]               r_stored, n_stored;
    svr_pkg::t_err             r_first, n_first;
    logic [7:0]                r_state, n_state;
    logic [31:0]               crc_next;
    logic                      id_mis;
    svr_pkg::t_err             item_err;
    svr_pkg::t_err             code;

    svr_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (i_byte),
        .o_crc  (crc_next)
    );

    // compare against the configured id bytes
    always_comb begin
        id_mis = 1'b0;
        for (int k = 0; k < ID_BYTES; k++) begin
            if (r_count == svr_pkg::CNT_W'(svr_pkg::ID_FIRST_POS + k) && i_byte != i_id[k]) begin
                id_mis = 1'b1;
            end
        end
    end

    // per-position field check
    always_comb begin
        item_err = svr_pkg::ERR_OK;
        n_state  = r_state;
        n_stored = r_stored;
        if (r_count < svr_pkg::POS_VERSION_LO) begin
            if (i_byte != svr_pkg::magic_byte(r_count[1:0])) item_err = svr_pkg::ERR_MAGIC;
        end else if (r_count == svr_pkg::POS_VERSION_LO) begin
            if (i_byte != svr_pkg::REC_VERSION_LO) item_err = svr_pkg::ERR_VERSION;
        end else if (r_count == svr_pkg::POS_VERSION_HI) begin
            if (i_byte != svr_pkg::REC_VERSION_HI) item_err = svr_pkg::ERR_VERSION;
        end else if (r_count == svr_pkg::POS_STATE) begin
            n_state = i_byte;
            if (i_byte != svr_pkg::ST_UNSPENT && i_byte != svr_pkg::ST_SPENT) begin
                item_err = svr_pkg::ERR_STATE;
            end
        end else if (r_count == svr_pkg::POS_RESERVED) begin
            if (i_byte != svr_pkg::REC_RESERVED) item_err = svr_pkg::ERR_RESERVED;
        end else if (r_count < svr_pkg::POS_CRC_FIRST) begin
            if (id_mis) item_err = svr_pkg::ERR_ID;
        end else if (r_count <= svr_pkg::POS_LAST) begin
            n_stored = r_stored | ({24'b0, i_byte} << {r_count[1:0], 3'b000});
        end
    end

    // next record state
    always_comb begin
        n_crc   = (r_count < svr_pkg::POS_CRC_FIRST) ? crc_next : r_crc;
        n_first = svr_pkg::pick_err(r_first, item_err);
        n_count = (r_count != svr_pkg::COUNT_MAX) ? r_count + 1'b1 : r_count;
    end

    // verdict priority: length, content, crc, spent
    always_comb begin
        if (r_count != svr_pkg::POS_LAST) begin
            code = svr_pkg::ERR_LENGTH;
        end else if (n_first != svr_pkg::ERR_OK) begin
            code = n_first;
        end else if ((r_crc ^ svr_pkg::CRC_ONES) != n_stored) begin
            code = svr_pkg::ERR_CRC;
        end else if (i_require_unspent && n_state == svr_pkg::ST_SPENT) begin
            code = svr_pkg::ERR_SPENT;
        end else begin
            code = svr_pkg::ERR_OK;
        end
        o_verdict.ok    = (code == svr_pkg::ERR_OK);
        o_verdict.code  = code;
        o_verdict.state = n_state;
        o_verdict_valid = i_advance && i_last;
    end

    // record state registers, cleared after each verdict
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_last)) begin
            r_count  <= '0;
            r_crc    <= svr_pkg::CRC_ONES;
            r_stored <= '0;
            r_first  <= svr_pkg::ERR_OK;
            r_state  <= '0;
        end else if (i_advance) begin
            r_count  <= n_count;
            r_crc    <= n_crc;
            r_stored <= n_stored;
            r_first  <= n_first;
            r_state  <= n_state;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/svr_checker.sv]
`default_nettype none

module svr_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_record_ok,
    input wire logic [3:0] i_error_code,
    input wire logic [7:0] i_record_state
);

    // no verdict right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("verdict valid after reset");

    // ok flag matches a zero code
    a_ok_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_record_ok == (i_error_code == svr_pkg::ERR_OK)))
        else $error("record_ok disagrees with error_code");

    // codes stay within the defined set
    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_error_code <= svr_pkg::ERR_SPENT))
        else $error("error_code out of range");

    // a passing record carries a legal state byte
    a_ok_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_record_ok) |->
            (i_record_state == svr_pkg::ST_UNSPENT || i_record_state == svr_pkg::ST_SPENT))
        else $error("passing record with bad state byte");

    // stalled verdict holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_record_ok) && $stable(i_error_code)
             && $stable(i_record_state)))
        else $error("stalled verdict changed");

endmodule

bind state_record_validator_top svr_checker u_svr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_record_ok    (o_result.record_ok),
    .i_error_code   (o_result.error_code),
    .i_record_state (o_result.record_state)
);

`default_nettype wire
